@@ hdl/fra_pkg.sv @@
// Package for the fenced ring allocator: status codes, command and status words.
// No dependencies.
package fra_pkg;

    localparam logic [2:0] ST_GRANT     = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_Q_FULL    = 3'd3;
    localparam logic [2:0] ST_FINISH    = 3'd4;

    localparam int SIZE_W   = 33;
    localparam int ALIGN_W  = 34;
    localparam int FENCE_W  = 48;
    localparam int OFFSET_W = 32;
    localparam logic [ALIGN_W-1:0] MIN_ALIGN = 34'd256;

    typedef struct packed {
        logic       load;
        logic       align_step;
        logic       round;
        logic       div_step;
        logic       place;
        logic       span;
        logic       grant;
        logic       pop;
        logic       res_set;
        logic [2:0] res_code;
        logic       out_load;
    } fra_cmd_t;

    typedef struct packed {
        logic is_finish;
        logic too_large;
        logic q_full;
        logic align_done;
        logic div_last;
        logic no_space;
        logic pop_ok;
        logic out_free;
    } fra_sts_t;

endpackage

@@ hdl/fra_if.sv @@
// Handshake channel interfaces for request and response words.
// Depends on nothing.
interface fra_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [32:0] req_size;
    logic [32:0] req_align;
    logic [47:0] done_fence;

    modport source (output valid, req_type, req_size, req_align, done_fence, input ready);
    modport sink   (input valid, req_type, req_size, req_align, done_fence, output ready);
endinterface

interface fra_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] grant_offset;
    logic [32:0] grant_size;
    logic [47:0] grant_fence;
    logic [47:0] tail_now;

    modport source (output valid, status, grant_offset, grant_size, grant_fence, tail_now,
                    input ready);
    modport sink   (input valid, status, grant_offset, grant_size, grant_fence, tail_now,
                    output ready);
endinterface

@@ hdl/fra_ctrl.sv @@
// Sequencer for the fenced ring allocator.
// Depends on fra_pkg; drives fra_dp through command word.
module fra_ctrl
    import fra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fra_sts_t sts,
    output fra_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHK0   = 11'b000_0000_0010,
        S_ALIGN  = 11'b000_0000_0100,
        S_ROUND  = 11'b000_0000_1000,
        S_DIV    = 11'b000_0001_0000,
        S_PLACE  = 11'b000_0010_0000,
        S_DIST   = 11'b000_0100_0000,
        S_DECIDE = 11'b000_1000_0000,
        S_FWAIT  = 11'b001_0000_0000,
        S_FCHK   = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK0;
                end
            end
            S_CHK0:
            begin
                priority if (sts.is_finish)
                    state_next = S_FWAIT;
                else if (sts.too_large)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_TOO_LARGE;
                    state_next   = S_RESP;
                end
                else if (sts.q_full)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_Q_FULL;
                    state_next   = S_RESP;
                end
                else
                    state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                if (sts.align_done)
                    state_next = S_ROUND;
                else
                    cmd.align_step = 1'b1;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.span   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.no_space)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NO_SPACE;
                end
                else
                    cmd.grant = 1'b1;
                state_next = S_RESP;
            end
            S_FWAIT:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.pop_ok)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_FWAIT;
                end
                else
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_FINISH;
                    state_next   = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/fra_dp.sv @@
// Datapath: ring pointers, fence counter, pending queue memory, remainder unit,
// result and output registers. Depends on fra_pkg; commanded by fra_ctrl.
module fra_dp
    import fra_pkg::*;
#(
    parameter int PENDING_DEPTH = 64,
    parameter int POS_WIDTH     = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_data,
    input  logic                in_type,
    input  logic [SIZE_W-1:0]   in_size,
    input  logic [SIZE_W-1:0]   in_align,
    input  logic [FENCE_W-1:0]  in_done,
    input  fra_cmd_t            cmd,
    output fra_sts_t            sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          out_status,
    output logic [OFFSET_W-1:0] out_offset,
    output logic [SIZE_W-1:0]   out_size,
    output logic [FENCE_W-1:0]  out_fence,
    output logic [FENCE_W-1:0]  out_tail
);

    localparam int P   = POS_WIDTH;
    localparam int IW  = $clog2(PENDING_DEPTH);
    localparam int CW  = $clog2(PENDING_DEPTH + 1);
    localparam int DCW = $clog2(POS_WIDTH + 1);

    typedef struct packed {
        logic [P-1:0]       end_pos;
        logic [FENCE_W-1:0] fence;
    } pend_t;

    pend_t mem [PENDING_DEPTH];
    pend_t rd_word_reg;

    logic [SIZE_W-1:0]  ring_reg;
    logic [P-1:0]       head_reg, tail_reg;
    logic [FENCE_W-1:0] fence_reg;
    logic [IW-1:0]      rd_reg, wr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               out_valid_reg;

    logic               type_reg;
    logic [SIZE_W-1:0]  size_reg, align_in_reg;
    logic [FENCE_W-1:0] done_reg;
    logic [ALIGN_W-1:0] p_reg, asize_reg, rem_reg;
    logic [P-1:0]       ahead_reg, dsh_reg, dist_reg;
    logic [DCW-1:0]     dcnt_reg;

    logic [2:0]          res_status_reg;
    logic [OFFSET_W-1:0] res_off_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic [FENCE_W-1:0]  res_fence_reg;

    logic [2:0]          out_status_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic [FENCE_W-1:0]  out_fence_reg;
    logic [FENCE_W-1:0]  out_tail_reg;

    logic [ALIGN_W-1:0] amask;
    logic [ALIGN_W-1:0] asize_next;
    logic [P:0]         ahead_sum, amask_w;
    logic [P-1:0]       ahead_rnd;
    logic [ALIGN_W-1:0] rem_sh, rem_next;
    logic               wrap_need;
    logic [P-1:0]       ahead_wrap;
    logic [P-1:0]       head_new;
    logic [FENCE_W-1:0] fence_inc;
    logic [IW-1:0]      rd_next, wr_next;

    assign amask      = p_reg - ALIGN_W'(1);
    assign asize_next = (ALIGN_W'(size_reg) + amask) & ~amask;
    assign amask_w    = (P+1)'(amask);
    assign ahead_sum  = (P+1)'(head_reg) + amask_w;
    assign ahead_rnd  = P'(ahead_sum & ~amask_w);

    assign rem_sh   = {rem_reg[ALIGN_W-2:0], dsh_reg[P-1]};
    assign rem_next = (rem_sh >= ALIGN_W'(ring_reg)) ? rem_sh - ALIGN_W'(ring_reg) : rem_sh;

    assign wrap_need  = ((ALIGN_W+1)'(rem_reg) + (ALIGN_W+1)'(asize_reg))
                        > (ALIGN_W+1)'(ring_reg);
    assign ahead_wrap = ahead_reg - P'(rem_reg) + P'(ring_reg);

    assign head_new  = ahead_reg + P'(asize_reg);
    assign fence_inc = fence_reg + FENCE_W'(1);
    assign rd_next   = (rd_reg == IW'(PENDING_DEPTH - 1)) ? '0 : rd_reg + IW'(1);
    assign wr_next   = (wr_reg == IW'(PENDING_DEPTH - 1)) ? '0 : wr_reg + IW'(1);

    always_comb
    begin
        sts.is_finish  = type_reg;
        sts.too_large  = (ring_reg == '0) || (size_reg > ring_reg);
        sts.q_full     = (cnt_reg >= CW'(PENDING_DEPTH));
        sts.align_done = (p_reg >= ALIGN_W'(align_in_reg));
        sts.div_last   = (dcnt_reg == DCW'(1));
        sts.no_space   = (dist_reg > P'(ring_reg)) ||
                         (((P+1)'(asize_reg) + (P+1)'(dist_reg)) > (P+1)'(ring_reg));
        sts.pop_ok     = (cnt_reg != '0) && (rd_word_reg.fence <= done_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // queue memory, registered read at the head of the queue
    always_ff @(posedge clk)
    begin
        if (cmd.grant)
            mem[wr_reg] <= '{end_pos: head_new, fence: fence_inc};
        rd_word_reg <= mem[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= SIZE_W'(65536);
            head_reg      <= '0;
            tail_reg      <= '0;
            fence_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ring_reg <= cfg_data;
            if (cmd.grant)
            begin
                head_reg  <= head_new;
                fence_reg <= fence_inc;
                wr_reg    <= wr_next;
                cnt_reg   <= cnt_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                tail_reg <= rd_word_reg.end_pos;
                rd_reg   <= rd_next;
                cnt_reg  <= cnt_reg - CW'(1);
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg     <= in_type;
            size_reg     <= in_size;
            align_in_reg <= in_align;
            done_reg     <= in_done;
            p_reg        <= MIN_ALIGN;
        end
        if (cmd.align_step)
            p_reg <= {p_reg[ALIGN_W-2:0], 1'b0};
        if (cmd.round)
        begin
            asize_reg <= asize_next;
            ahead_reg <= ahead_rnd;
            dsh_reg   <= ahead_rnd;
            rem_reg   <= '0;
            dcnt_reg  <= DCW'(POS_WIDTH);
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            dsh_reg  <= {dsh_reg[P-2:0], 1'b0};
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
        if (cmd.place && wrap_need)
        begin
            ahead_reg <= ahead_wrap;
            rem_reg   <= '0;
        end
        if (cmd.span)
            dist_reg <= ahead_reg - tail_reg;
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_off_reg    <= '0;
            res_size_reg   <= '0;
            res_fence_reg  <= '0;
        end
        else if (cmd.grant)
        begin
            res_status_reg <= ST_GRANT;
            res_off_reg    <= rem_reg[OFFSET_W-1:0];
            res_size_reg   <= size_reg;
            res_fence_reg  <= fence_inc;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_size_reg   <= res_size_reg;
            out_fence_reg  <= res_fence_reg;
            out_tail_reg   <= FENCE_W'(tail_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_offset = out_off_reg;
    assign out_size   = out_size_reg;
    assign out_fence  = out_fence_reg;
    assign out_tail   = out_tail_reg;

endmodule

@@ hdl/fenced_ring_allocator_top.sv @@
// Top level of the fenced ring allocator: sequencer plus datapath.
// Depends on fra_pkg, fra_if, fra_ctrl, fra_dp.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, req_size, req_align, done_fence
//  rsp      out  valid/ready   status, grant_offset, grant_size, grant_fence, tail_now
//  cfg      in   cfg_we        cfg_data = ring_size
//
// One word in flight. Allocate: the alignment is doubled from 256 until it covers
// req_align (0..25 doublings), then the bit-serial remainder unit runs over
// POS_WIDTH bits; refusals on size or a full queue skip both. Finish: retires
// entries one by one, each through a registered queue read.
// Reset clears pointers and counts at once; queue memory needs no clearing.
// A stalled rsp holds its word; the next req is taken meanwhile.
module fenced_ring_allocator_top
    import fra_pkg::*;
#(
    parameter int PENDING_DEPTH = 64,
    parameter int POS_WIDTH     = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    fra_req_if.sink           req,
    fra_rsp_if.source         rsp,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_data
);

    fra_cmd_t cmd;
    fra_sts_t sts;

    fra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fra_dp #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .POS_WIDTH     (POS_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_type    (req.req_type),
        .in_size    (req.req_size),
        .in_align   (req.req_align),
        .in_done    (req.done_fence),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_offset (rsp.grant_offset),
        .out_size   (rsp.grant_size),
        .out_fence  (rsp.grant_fence),
        .out_tail   (rsp.tail_now)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second word accepted while busy");

    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_GRANT |->
            rsp.grant_offset == '0 && rsp.grant_size == '0 && rsp.grant_fence == '0)
        else $error("refused or finish word carries grant fields");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.align_step, cmd.round, cmd.div_step, cmd.place,
                  cmd.span, cmd.grant, cmd.pop, cmd.res_set, cmd.out_load}))
        else $error("overlapping datapath commands");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> !sts.q_full)
        else $error("grant into a full queue");

endmodule
